>>> sv/fmmp_pkg.sv
// Shared constants and state types for the Fibonacci-mod-m matrix power block.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package fmmp_pkg;

    // Fixed port widths
    localparam int INDEX_W = 64;
    localparam int REM_W   = 32;
    localparam int MOD_W   = 32;

    // Defaults for the top level parameters
    localparam int INDEX_BITS_DEF = 64;
    localparam int MOD_BITS_DEF   = 32;

    localparam logic [MOD_W-1:0] MODULUS_RESET = 32'd2;

    // Entries of Q = [[0,1],[1,1]] and of the identity, each entry 0 or 1,
    // bit i holds entry i in row-major order.
    localparam logic [3:0] BASE_ONES = 4'b1110;
    localparam logic [3:0] UNIT_ONES = 4'b1001;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BIT,
        ST_ACC_RUN,
        ST_PW_RUN,
        ST_DONE
    } fmmp_state_t;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_RUN,
        MM_SUM
    } mm_state_t;

endpackage

`default_nettype wire

>>> sv/fmmp_mulmod.sv
// Bit-serial modular multiplier lane: one multiplier bit per step, MSB first.
// Depends on fmmp_pkg for the default width only.
`default_nettype none

module fmmp_mulmod #(
    parameter int MOD_BITS = fmmp_pkg::MOD_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                load,
    input  wire logic                step,
    input  wire logic [MOD_BITS-1:0] x_in,
    input  wire logic [MOD_BITS-1:0] y_in,
    input  wire logic [MOD_BITS-1:0] modulus,
    output logic      [MOD_BITS-1:0] prod
);

    logic [MOD_BITS-1:0] x_reg, x_next;
    logic [MOD_BITS-1:0] y_reg, y_next;
    logic [MOD_BITS-1:0] prod_reg, prod_next;

    logic [MOD_BITS:0]   dbl;
    logic [MOD_BITS-1:0] dbl_red;
    logic [MOD_BITS:0]   sum;
    logic [MOD_BITS-1:0] addend;

    always_comb begin
        // prod = 2*prod + bit*y, both reduced by one conditional subtract
        dbl     = {prod_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, modulus}) ? MOD_BITS'(dbl - {1'b0, modulus})
                                           : MOD_BITS'(dbl);
        addend  = x_reg[MOD_BITS-1] ? y_reg : '0;
        sum     = {1'b0, dbl_red} + {1'b0, addend};

        x_next    = x_reg;
        y_next    = y_reg;
        prod_next = prod_reg;
        if (load) begin
            x_next    = x_in;
            y_next    = y_in;
            prod_next = '0;
        end else if (step) begin
            x_next    = x_reg << 1;
            prod_next = (sum >= {1'b0, modulus}) ? MOD_BITS'(sum - {1'b0, modulus})
                                                 : MOD_BITS'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> sv/fmmp_matmul.sv
// 2x2 modular matrix product on eight bit-serial lanes plus one summing step.
// Depends on fmmp_pkg and fmmp_mulmod.
`default_nettype none

module fmmp_matmul #(
    parameter int MOD_BITS = fmmp_pkg::MOD_BITS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     start,
    input  wire logic [3:0][MOD_BITS-1:0] a_mat,
    input  wire logic [3:0][MOD_BITS-1:0] b_mat,
    input  wire logic [MOD_BITS-1:0]      modulus,
    output logic                          done,
    output logic      [3:0][MOD_BITS-1:0] c_mat
);

    localparam int CNT_W = (MOD_BITS > 1) ? $clog2(MOD_BITS) : 1;

    fmmp_pkg::mm_state_t state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      done_reg;
    logic [3:0][MOD_BITS-1:0]  c_reg;
    logic [7:0][MOD_BITS-1:0]  lane_prod;
    logic [3:0][MOD_BITS-1:0]  c_sum;
    logic                      lane_load;
    logic                      lane_step;

    assign lane_load = (state_reg == fmmp_pkg::MM_IDLE) && start;
    assign lane_step = (state_reg == fmmp_pkg::MM_RUN);

    // Lane 2*i+j forms a[row(i), j] * b[j, col(i)]
    for (genvar ln = 0; ln < 8; ln++) begin : g_lane
        fmmp_mulmod #(.MOD_BITS(MOD_BITS)) u_lane (
            .aclk    (aclk),
            .load    (lane_load),
            .step    (lane_step),
            .x_in    (a_mat[2 * ((ln / 2) / 2) + (ln % 2)]),
            .y_in    (b_mat[2 * (ln % 2) + ((ln / 2) % 2)]),
            .modulus (modulus),
            .prod    (lane_prod[ln])
        );
    end

    always_comb begin
        logic [MOD_BITS:0] s;
        for (int i = 0; i < 4; i++) begin
            s        = {1'b0, lane_prod[2*i]} + {1'b0, lane_prod[2*i+1]};
            c_sum[i] = (s >= {1'b0, modulus}) ? MOD_BITS'(s - {1'b0, modulus})
                                              : MOD_BITS'(s);
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            fmmp_pkg::MM_IDLE: begin
                if (start) begin
                    state_next = fmmp_pkg::MM_RUN;
                    cnt_next   = CNT_W'(MOD_BITS - 1);
                end
            end
            fmmp_pkg::MM_RUN: begin
                if (cnt_reg == '0) begin
                    state_next = fmmp_pkg::MM_SUM;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            fmmp_pkg::MM_SUM: begin
                state_next = fmmp_pkg::MM_IDLE;
            end
            default: begin
                state_next = fmmp_pkg::MM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fmmp_pkg::MM_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= (state_reg == fmmp_pkg::MM_SUM);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == fmmp_pkg::MM_SUM) begin
            c_reg <= c_sum;
        end
    end

    assign done  = done_reg;
    assign c_mat = c_reg;

endmodule

`default_nettype wire

>>> sv/fibonacci_mod_by_matrix_power_core.sv
// Top level: F(n) mod m by square-and-multiply of Q = [[0,1],[1,1]].
// Depends on fmmp_pkg and fmmp_matmul (which uses fmmp_mulmod).
//
// Usage:
//  - Write the modulus through cfg_wr_en / cfg_wr_data while the block is idle.
//    Reset loads a modulus of 2. Moduli of 0 and 1 answer 0.
//  - Present an index on s_fib_index with s_valid; the word is taken when
//    s_valid and s_ready are both high. One index is worked on at a time.
//  - The remainder leaves on m_fib_remainder with m_valid and is taken when
//    m_ready is high. The output register holds it while the receiver stalls,
//    and a new index is taken meanwhile; a finished item waits in its final
//    state until the output register is free.
// Work per item, for each index bit up to the highest set bit: one matrix
//  square when the bit is clear, a multiply into the accumulator and then a
//  square when it is set. The bit-serial multiplier lanes take one multiplier
//  bit per cycle. Index 0 or modulus 0 skips the matrix products and goes
//  straight to the hand-off.
// Reset is synchronous, active low, and resets the control state and the modulus only.
`default_nettype none

module fibonacci_mod_by_matrix_power_core #(
    parameter int INDEX_BITS = fmmp_pkg::INDEX_BITS_DEF,
    parameter int MOD_BITS   = fmmp_pkg::MOD_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic [fmmp_pkg::MOD_W-1:0]   cfg_wr_data,
    // index words in
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [fmmp_pkg::INDEX_W-1:0] s_fib_index,
    // remainder words out
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [fmmp_pkg::REM_W-1:0]   m_fib_remainder
);

    fmmp_pkg::fmmp_state_t state_reg, state_next;

    logic [fmmp_pkg::MOD_W-1:0] modulus_reg;   // configuration register
    logic [MOD_BITS-1:0]        m_eff_reg;     // modulus snapshot for this item
    logic [INDEX_BITS-1:0]      idx_reg;       // remaining index bits, LSB next
    logic [3:0][MOD_BITS-1:0]   acc_reg;       // running product
    logic [3:0][MOD_BITS-1:0]   pw_reg;        // Q^(2^k)
    logic [MOD_BITS-1:0]        out_reg;
    logic                       m_valid_reg;

    logic                       in_accept;
    logic                       out_load;
    logic                       mm_start;
    logic                       mm_done;
    logic [3:0][MOD_BITS-1:0]   mm_a;
    logic [3:0][MOD_BITS-1:0]   mm_c;
    logic [MOD_BITS-1:0]        mod_cur;
    logic [MOD_BITS-1:0]        one_val;
    logic [INDEX_BITS-1:0]      idx_in;

    assign mod_cur = modulus_reg[MOD_BITS-1:0];
    assign idx_in  = s_fib_index[INDEX_BITS-1:0];
    // A 1 reduced by a modulus of 1 is 0
    assign one_val = (mod_cur == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

    // Multiply the accumulator by the power on a set bit; every other product squares the power
    assign mm_a = (state_reg == fmmp_pkg::ST_BIT && idx_reg[0]) ? acc_reg : pw_reg;

    fmmp_matmul #(.MOD_BITS(MOD_BITS)) u_matmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mm_start),
        .a_mat   (mm_a),
        .b_mat   (pw_reg),
        .modulus (m_eff_reg),
        .done    (mm_done),
        .c_mat   (mm_c)
    );

    // Sequencer: one pass per index bit until no set bit remains
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        mm_start   = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            fmmp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    // Modulus 0 or index 0: identity's top-right entry, 0
                    if (mod_cur == '0 || idx_in == '0) begin
                        state_next = fmmp_pkg::ST_DONE;
                    end else begin
                        state_next = fmmp_pkg::ST_BIT;
                    end
                end
            end
            fmmp_pkg::ST_BIT: begin
                if (idx_reg == '0) begin
                    state_next = fmmp_pkg::ST_DONE;
                end else begin
                    mm_start = 1'b1;
                    state_next = idx_reg[0] ? fmmp_pkg::ST_ACC_RUN : fmmp_pkg::ST_PW_RUN;
                end
            end
            fmmp_pkg::ST_ACC_RUN: begin
                if (mm_done) begin
                    mm_start   = 1'b1;   // square right away
                    state_next = fmmp_pkg::ST_PW_RUN;
                end
            end
            fmmp_pkg::ST_PW_RUN: begin
                if (mm_done) begin
                    state_next = fmmp_pkg::ST_BIT;
                end
            end
            fmmp_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = fmmp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fmmp_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fmmp_pkg::ST_IDLE;
            modulus_reg <= fmmp_pkg::MODULUS_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                modulus_reg <= cfg_wr_data;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers: load on accept, advance on each finished product
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            idx_reg   <= idx_in;
            m_eff_reg <= mod_cur;
            for (int i = 0; i < 4; i++) begin
                pw_reg[i]  <= fmmp_pkg::BASE_ONES[i] ? one_val : '0;
                acc_reg[i] <= fmmp_pkg::UNIT_ONES[i] ? one_val : '0;
            end
        end else if (state_reg == fmmp_pkg::ST_ACC_RUN && mm_done) begin
            acc_reg <= mm_c;
        end else if (state_reg == fmmp_pkg::ST_PW_RUN && mm_done) begin
            pw_reg  <= mm_c;
            idx_reg <= idx_reg >> 1;
        end
        if (out_load) begin
            out_reg <= acc_reg[1];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_fib_remainder = fmmp_pkg::REM_W'(out_reg);

    // Checks on the sequencer and the datapath

    // A finished product only arrives while the sequencer waits for one
    assert property (@(posedge aclk) disable iff (!aresetn)
        mm_done |-> (state_reg == fmmp_pkg::ST_ACC_RUN || state_reg == fmmp_pkg::ST_PW_RUN))
        else $error("matrix product finished outside a run state");

    // Checked entries of the working matrices stay reduced below the modulus
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != fmmp_pkg::ST_IDLE && m_eff_reg != '0)
        |-> (acc_reg[1] < m_eff_reg && pw_reg[1] < m_eff_reg && pw_reg[3] < m_eff_reg))
        else $error("matrix entry not reduced");

    // A delivered remainder is below its modulus
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && m_eff_reg != '0) |=> (out_reg < m_eff_reg))
        else $error("remainder not below modulus");

    // The sequencer never starts a product while an index is taken or the result is handed off
    assert property (@(posedge aclk) disable iff (!aresetn)
        mm_start |-> !in_accept && !out_load)
        else $error("product started during hand-off");

endmodule

`default_nettype wire
